// ----- hdl/cpc_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the packet classifier.
`default_nettype none

package cpc_pkg;

   // Payload bytes per packet (default, top-level parameter overrides)
   localparam int DATA_BYTES_DEF = 16;

   // CRC-8, polynomial x^8 + x^2 + x + 1, MSB first
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_INIT = 8'h00;

   // Register reset values
   localparam logic [7:0] ACK_CODE_RST  = 8'h15;
   localparam logic [7:0] RETX_CODE_RST = 8'h19;
   localparam logic [7:0] PAD_VALUE_RST = 8'hAA;

   // Register file geometry: word-aligned 32-bit registers
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_ACK_CODE  = 2'd0,
      REG_RETX_CODE = 2'd1,
      REG_PAD_VALUE = 2'd2
   } reg_index_type;

   // Configuration handed from the register file to the datapath
   typedef struct packed {
      logic [7:0] ack_code;
      logic [7:0] retx_code;
      logic [7:0] pad_value;
   } cfg_type;

   // One byte of CRC update, eight shift/xor steps
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         if (v[7]) begin
            v = {v[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[6:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/cpc_csr.sv -----
// APB-style register file holding the ack, retx and pad codes.
`default_nettype none

module cpc_csr
   import cpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   logic          wr_en;
   reg_index_type reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   // Word index; byte offset within the word is ignored
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ack_code  <= ACK_CODE_RST;
         cfg_ff.retx_code <= RETX_CODE_RST;
         cfg_ff.pad_value <= PAD_VALUE_RST;
      end else if (wr_en) begin
         unique case (reg_index)
            REG_ACK_CODE:  cfg_ff.ack_code  <= pwdata[7:0];
            REG_RETX_CODE: cfg_ff.retx_code <= pwdata[7:0];
            REG_PAD_VALUE: cfg_ff.pad_value <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_ACK_CODE:  prdata[7:0] = cfg_ff.ack_code;
         REG_RETX_CODE: prdata[7:0] = cfg_ff.retx_code;
         REG_PAD_VALUE: prdata[7:0] = cfg_ff.pad_value;
         default:       prdata      = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ----- hdl/cpc_parser.sv -----
// Byte input register, packet tracking state, CRC update and result register.
`default_nettype none

module cpc_parser
   import cpc_pkg::*;
#(
   parameter int DATA_BYTES = DATA_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_crc_ok,
   output logic            rsp_is_ack,
   output logic            rsp_is_retx,
   output logic [7:0]      rsp_computed_crc
);

   // Position runs 0 (length) .. DATA_BYTES+1 (crc byte)
   localparam int POS_W = $clog2(DATA_BYTES + 2);
   localparam logic [POS_W-1:0] POS_LEN   = '0;
   localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(DATA_BYTES);

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Packet state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       crc_ff, crc_in;
   logic             len_one_ff, len_one_in;
   logic             first_ack_ff, first_ack_in;
   logic             first_retx_ff, first_retx_in;
   logic             pad_ok_ff, pad_ok_in;

   // Result register
   logic       rsp_valid_ff;
   logic       crc_ok_ff, is_ack_ff, is_retx_ff;
   logic [7:0] crc_out_ff;

   logic       at_len, at_data, at_crc;
   logic       stall, fire, emit;
   logic [7:0] crc_next;
   logic       match_ok, ctrl_ok;

   assign at_len  = (pos_ff == POS_LEN);
   assign at_data = (pos_ff >= POS_FIRST) && (pos_ff <= POS_LAST);
   assign at_crc  = !at_len && !at_data;

   // Only a crc byte needs the result slot; it waits while a result is untaken
   assign stall     = in_valid_ff && at_crc && rsp_valid_ff && !rsp_ready;
   assign fire      = in_valid_ff && !stall;
   assign emit      = fire && at_crc;
   assign req_ready = !in_valid_ff || !stall;

   assign crc_next = crc8_update(crc_ff, in_byte_ff);
   assign match_ok = (in_byte_ff == crc_ff);
   assign ctrl_ok  = match_ok && len_one_ff && pad_ok_ff;

   // Next packet state
   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      len_one_in    = len_one_ff;
      first_ack_in  = first_ack_ff;
      first_retx_in = first_retx_ff;
      pad_ok_in     = pad_ok_ff;
      if (fire) begin
         if (at_len) begin
            len_one_in = (in_byte_ff == 8'd1);
            crc_in     = crc_next;
            pos_in     = POS_FIRST;
         end else if (at_data) begin
            if (pos_ff == POS_FIRST) begin
               first_ack_in  = (in_byte_ff == cfg.ack_code);
               first_retx_in = (in_byte_ff == cfg.retx_code);
            end else if (in_byte_ff != cfg.pad_value) begin
               pad_ok_in = 1'b0;
            end
            crc_in = crc_next;
            pos_in = pos_ff + POS_W'(1);
         end else begin
            // crc byte closes the packet
            pos_in        = POS_LEN;
            crc_in        = CRC_INIT;
            len_one_in    = 1'b0;
            first_ack_in  = 1'b0;
            first_retx_in = 1'b0;
            pad_ok_in     = 1'b1;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Packet state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= POS_LEN;
         crc_ff        <= CRC_INIT;
         len_one_ff    <= 1'b0;
         first_ack_ff  <= 1'b0;
         first_retx_ff <= 1'b0;
         pad_ok_ff     <= 1'b1;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         len_one_ff    <= len_one_in;
         first_ack_ff  <= first_ack_in;
         first_retx_ff <= first_retx_in;
         pad_ok_ff     <= pad_ok_in;
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (emit) begin
         crc_ok_ff  <= match_ok;
         is_ack_ff  <= ctrl_ok && first_ack_ff;
         is_retx_ff <= ctrl_ok && first_retx_ff;
         crc_out_ff <= crc_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_crc_ok       = crc_ok_ff;
   assign rsp_is_ack       = is_ack_ff;
   assign rsp_is_retx      = is_retx_ff;
   assign rsp_computed_crc = crc_out_ff;

endmodule

`default_nettype wire

// ----- hdl/crc8_packet_classifier.sv -----
// Top level of the CRC-8 packet classifier: register file and byte parser.
`default_nettype none

// Packets arrive one byte per transfer: a length byte, DATA_BYTES payload
// bytes, then a CRC byte. A CRC-8 (poly 0x07, init 0, MSB first) runs over the
// length and payload bytes; on the CRC byte one result transfer carries
// crc_ok, is_ack, is_retx and the computed CRC. The block takes one byte per
// cycle while no CRC byte is held up; a CRC byte goes through an input
// register and then the result register to give its result. Only a CRC byte can
// be held up, and only while the previous result is still untaken; other
// bytes keep flowing. There is no resynchronization on lost or extra bytes.
// ack_code, retx_code and pad_value sit at byte addresses 0x0, 0x4 and 0x8.

module crc8_packet_classifier
   import cpc_pkg::*;
#(
   parameter int DATA_BYTES = DATA_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   // Byte input
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_rx_byte,
   // Result output
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_crc_ok,
   output logic                       rsp_is_ack,
   output logic                       rsp_is_retx,
   output logic [7:0]                 rsp_computed_crc
);

   cfg_type cfg;

   cpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cpc_parser #(
      .DATA_BYTES (DATA_BYTES)
   ) u_parser (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_crc_ok       (rsp_crc_ok),
      .rsp_is_ack       (rsp_is_ack),
      .rsp_is_retx      (rsp_is_retx),
      .rsp_computed_crc (rsp_computed_crc)
   );

endmodule

`default_nettype wire
